// ===== hdl/calendar_date_day_offset_assert.svh =====
// Assertion macros shared by the calendar date day offset RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef CALENDAR_DATE_DAY_OFFSET_ASSERT_SVH
`define CALENDAR_DATE_DAY_OFFSET_ASSERT_SVH
`ifndef SYNTH
`define CDO_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define CDO_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define CDO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CDO_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define CDO_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define CDO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hdl/cdo_pkg.sv =====
// Shared types, constants and calendar tables for the date day offset block.
// No dependencies; used by cdo_step, cdo_conv and the top level.
`timescale 1ns / 1ps

package cdo_pkg;

	localparam logic ACTION_SET = 1'b0;
	localparam logic ACTION_ADD = 1'b1;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_DAY   = 2'd1;
	localparam logic [1:0] ST_BAD_MONTH = 2'd2;
	localparam logic [1:0] ST_BAD_YEAR  = 2'd3;

	localparam logic [11:0] YEAR_MIN  = 12'd1902;
	localparam logic [11:0] YEAR_MAX  = 12'd2037;
	localparam logic [11:0] YEAR_BASE = 12'd1901;

	// The stored date is kept as days since 1 January 1901.
	localparam logic [15:0] DAYS_MIN   = 16'd365;
	localparam logic [15:0] DAYS_MAX   = 16'd50038;
	localparam logic [15:0] DAYS_RESET = 16'd25202;

	typedef struct packed {
		logic [15:0] days;
		logic [1:0]  status;
	} step_res_t;

	function automatic logic [4:0] month_len(input logic [3:0] m);
		logic [4:0] len;
		case (m)
			4'd2: len = 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

	function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
		logic [8:0] s;
		case (m)
			4'd2:  s = 9'd31;
			4'd3:  s = 9'd59;
			4'd4:  s = 9'd90;
			4'd5:  s = 9'd120;
			4'd6:  s = 9'd151;
			4'd7:  s = 9'd181;
			4'd8:  s = 9'd212;
			4'd9:  s = 9'd243;
			4'd10: s = 9'd273;
			4'd11: s = 9'd304;
			4'd12: s = 9'd334;
			default: s = 9'd0;
		endcase
		if (leap && (m > 4'd2)) begin
			s = s + 9'd1;
		end
		return s;
	endfunction

endpackage

// ===== hdl/cdo_step.sv =====
// Date register and per-beat step logic: validates a set beat or applies a day offset.
// Depends on cdo_pkg and calendar_date_day_offset_assert.svh.
`timescale 1ns / 1ps
`include "calendar_date_day_offset_assert.svh"

module cdo_step (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic                action,
	input  logic [4:0]          day_in,
	input  logic [3:0]          month_in,
	input  logic [11:0]         year_in,
	input  logic signed [16:0]  day_offset,
	output cdo_pkg::step_res_t  res
);

	logic [15:0]        days_q;
	logic [3:0]         norm_month;
	logic [12:0]        norm_year;
	logic [25:0]        div25_prod;
	logic               norm_leap;
	logic [4:0]         len;
	logic [1:0]         set_status;
	logic [7:0]         year_ofs;
	logic [16:0]        set_days;
	logic signed [17:0] add_sum;
	logic               add_ok;

	always_comb begin
		norm_month = month_in;
		norm_year  = {1'b0, year_in};
		if (month_in == 4'd0) begin
			norm_month = 4'd12;
		end else if (month_in > 4'd12) begin
			norm_month = month_in - 4'd12;
			norm_year  = {1'b0, year_in} + 13'd1;
		end
	end

	// 7209 is the inverse of 25 modulo 8192, so a multiple of 25 maps onto 0..327.
	assign div25_prod = {13'd0, norm_year} * 26'd7209;
	assign norm_leap  = (norm_year[1:0] == 2'd0) &&
		((div25_prod[12:0] > 13'd327) || (norm_year[3:0] == 4'd0));

	always_comb begin
		len = cdo_pkg::month_len(norm_month);
		if ((norm_month == 4'd2) && norm_leap) begin
			len = 5'd29;
		end
		if ((day_in == 5'd0) || (day_in > len)) begin
			set_status = cdo_pkg::ST_BAD_DAY;
		end else if (norm_month != month_in) begin
			set_status = cdo_pkg::ST_BAD_MONTH;
		end else if ((year_in < cdo_pkg::YEAR_MIN) || (year_in > cdo_pkg::YEAR_MAX)) begin
			set_status = cdo_pkg::ST_BAD_YEAR;
		end else begin
			set_status = cdo_pkg::ST_OK;
		end
	end

	// Inside the year range every fourth year is a leap year, 2000 included.
	assign year_ofs = 8'(year_in - cdo_pkg::YEAR_BASE);
	assign set_days = {9'd0, year_ofs} * 17'd365 + {11'd0, year_ofs[7:2]}
		+ {8'd0, cdo_pkg::month_start(month_in, year_in[1:0] == 2'd0)}
		+ {12'd0, day_in} - 17'd1;

	assign add_sum = $signed({2'b00, days_q}) + 18'(day_offset);
	assign add_ok  = (add_sum >= $signed({2'b00, cdo_pkg::DAYS_MIN})) &&
		(add_sum <= $signed({2'b00, cdo_pkg::DAYS_MAX}));

	always_comb begin
		res.days   = days_q;
		res.status = cdo_pkg::ST_OK;
		if (action == cdo_pkg::ACTION_SET) begin
			res.status = set_status;
			if (set_status == cdo_pkg::ST_OK) begin
				res.days = set_days[15:0];
			end
		end else begin
			if (add_ok) begin
				res.days = add_sum[15:0];
			end else begin
				res.status = cdo_pkg::ST_BAD_YEAR;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			days_q <= cdo_pkg::DAYS_RESET;
		end else if (accept) begin
			days_q <= res.days;
		end
	end

	`CDO_ASSERT_ALWAYS(a_days_range, clk, arst_n, (days_q >= cdo_pkg::DAYS_MIN) && (days_q <= cdo_pkg::DAYS_MAX), "stored date left the year range")
	`CDO_ASSERT_NEXT(a_reject_keeps, clk, arst_n, accept && (res.status != cdo_pkg::ST_OK), $stable(days_q), "rejected beat changed the stored date")
	`CDO_ASSERT_IMPL(a_add_status, clk, arst_n, accept && (action == cdo_pkg::ACTION_ADD), (res.status == cdo_pkg::ST_OK) || (res.status == cdo_pkg::ST_BAD_YEAR), "add beat gave a set status")

endmodule

// ===== hdl/cdo_conv.sv =====
// Elastic four-stage pipeline that turns a day count into date, weekday and status.
// Depends on cdo_pkg and calendar_date_day_offset_assert.svh.
`timescale 1ns / 1ps
`include "calendar_date_day_offset_assert.svh"

module cdo_conv (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  cdo_pkg::step_res_t res,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [4:0]         day_out,
	output logic [3:0]         month_out,
	output logic [10:0]        year_out,
	output logic [2:0]         weekday,
	output logic [1:0]         status
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic adv_s1, adv_s2, adv_s3, adv_s4;

	logic [15:0] days_s1;
	logic [1:0]  st_s1;

	logic [32:0] cyc_prod;
	logic [15:0] days_s2;
	logic [5:0]  cyc_s2;
	logic [1:0]  st_s2;

	logic [16:0] cyc_days;
	logic [15:0] rem;
	logic [1:0]  yic;
	logic [8:0]  doy;
	logic [16:0] wd_x;
	logic [33:0] wd_prod;
	logic [16:0] wd_r;
	logic [8:0]  doy_s3;
	logic        leap_s3;
	logic [10:0] year_s3;
	logic [2:0]  wd_s3;
	logic [1:0]  st_s3;

	logic [3:0]  mon;
	logic [8:0]  mon_start;
	logic [8:0]  dom;

	assign adv_s4   = !v_s4 || out_ready;
	assign adv_s3   = !v_s3 || adv_s4;
	assign adv_s2   = !v_s2 || adv_s3;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
			if (adv_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			days_s1 <= res.days;
			st_s1   <= res.status;
		end
	end

	// Four-year cycles of 1461 days; 91868 / 2^27 is exact for any 16-bit count.
	assign cyc_prod = {17'd0, days_s1} * 33'd91868;

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			days_s2 <= days_s1;
			cyc_s2  <= cyc_prod[32:27];
			st_s2   <= st_s1;
		end
	end

	assign cyc_days = {11'd0, cyc_s2} * 17'd1461;
	assign rem      = days_s2 - cyc_days[15:0];

	always_comb begin
		if (rem >= 16'd1095) begin
			yic = 2'd3;
			doy = 9'(rem - 16'd1095);
		end else if (rem >= 16'd730) begin
			yic = 2'd2;
			doy = 9'(rem - 16'd730);
		end else if (rem >= 16'd365) begin
			yic = 2'd1;
			doy = 9'(rem - 16'd365);
		end else begin
			yic = 2'd0;
			doy = rem[8:0];
		end
	end

	// 1 January 1901 was a Tuesday, hence the bias of two.
	assign wd_x    = {1'b0, days_s2} + 17'd2;
	assign wd_prod = {17'd0, wd_x} * 34'd74899;
	assign wd_r    = wd_x - {2'b00, wd_prod[33:19]} * 17'd7;

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			doy_s3  <= doy;
			leap_s3 <= (yic == 2'd3);
			year_s3 <= 11'(cdo_pkg::YEAR_BASE) + {3'd0, cyc_s2, 2'b00} + {9'd0, yic};
			wd_s3   <= wd_r[2:0];
			st_s3   <= st_s2;
		end
	end

	always_comb begin
		mon = 4'd1;
		for (int i = 2; i <= 12; i++) begin
			if (doy_s3 >= cdo_pkg::month_start(4'(i), leap_s3)) begin
				mon = 4'(i);
			end
		end
		mon_start = cdo_pkg::month_start(mon, leap_s3);
		dom       = doy_s3 - mon_start + 9'd1;
	end

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			day_out   <= dom[4:0];
			month_out <= mon;
			year_out  <= year_s3;
			weekday   <= wd_s3;
			status    <= st_s3;
		end
	end

	assign out_valid = v_s4;

	`CDO_ASSERT_IMPL(a_full_stall, clk, arst_n, !in_ready, v_s1 && v_s2 && v_s3 && v_s4 && !out_ready, "input stalled with a free stage")
	`CDO_ASSERT_IMPL(a_year_range, clk, arst_n, out_valid, (year_out >= 11'(cdo_pkg::YEAR_MIN)) && (year_out <= 11'(cdo_pkg::YEAR_MAX)), "converted year out of range")
	`CDO_ASSERT_IMPL(a_date_fields, clk, arst_n, out_valid, (month_out >= 4'd1) && (month_out <= 4'd12) && (day_out >= 5'd1) && (weekday <= 3'd6), "converted date field out of range")

endmodule

// ===== hdl/calendar_date_day_offset.sv =====
// Top level of the calendar date day offset block.
// Depends on cdo_pkg, cdo_step and cdo_conv.
//
// Usage:
// The input channel (in_valid / in_ready) carries one command beat: action 0 sets a
// date from day_in, month_in and year_in after checking it, action 1 moves the stored
// date by the signed day_offset. The stored date is updated at the edge that accepts
// the beat, so the next beat may follow in the very next cycle.
// The output channel (out_valid / out_ready) returns one beat per command: the stored
// date after that command, its weekday (0 is Sunday) and a status code.
// Throughput is one beat per cycle while out_ready is high. Each beat passes four
// register stages; out_valid rises when the last of them holds it. The day count
// is held in the date register and turned back into a date by the four-year-cycle
// divider and month compares of the output pipeline.
// Reset clears the pipeline and loads Thursday, 1 January 1970.
// When out_ready is low the pipeline fills; in_ready drops only when all four stages
// hold a beat, and no beat is lost or reordered.
`timescale 1ns / 1ps

module calendar_date_day_offset (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               action,
	input  logic [4:0]         day_in,
	input  logic [3:0]         month_in,
	input  logic [11:0]        year_in,
	input  logic signed [16:0] day_offset,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [4:0]         day_out,
	output logic [3:0]         month_out,
	output logic [10:0]        year_out,
	output logic [2:0]         weekday,
	output logic [1:0]         status
);

	cdo_pkg::step_res_t step_res;
	logic               accept;

	assign accept = in_valid && in_ready;

	cdo_step u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.action     (action),
		.day_in     (day_in),
		.month_in   (month_in),
		.year_in    (year_in),
		.day_offset (day_offset),
		.res        (step_res)
	);

	cdo_conv u_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.res       (step_res),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.day_out   (day_out),
		.month_out (month_out),
		.year_out  (year_out),
		.weekday   (weekday),
		.status    (status)
	);

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the calendar date day offset block.
// Holds its own calendar arithmetic to predict every result beat; needs cdo_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;

	localparam int CLK_PERIOD    = 8;
	localparam int RANDOM_ITEMS  = 630;
	localparam int CALM_ITEMS    = 100;
	localparam int LONG_HOLD     = 80;
	localparam int DRAIN_LIMIT   = 5000;
	localparam int TIMEOUT_CYCLE = 400000;

	typedef struct {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [10:0] year;
		logic [2:0]  wday;
		logic [1:0]  stat;
	} date_beat_t;

	// Tracks the stored date and queues the beat each accepted command must return.
	class date_tracker;
		int cur_day;
		int cur_month;
		int cur_year;
		date_beat_t expected_dates[$];
		int errors;
		int set_count;
		int add_count;
		int status_count[4];

		function new();
			cur_day = 1;
			cur_month = 1;
			cur_year = 1970;
			errors = 0;
			set_count = 0;
			add_count = 0;
			foreach (status_count[i]) status_count[i] = 0;
		endfunction

		function bit leap_year(int y);
			return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
		endfunction

		// m must already be folded into 1..12.
		function int month_days(int m, int y);
			int len;
			case (m)
				2: len = leap_year(y) ? 29 : 28;
				4, 6, 9, 11: len = 30;
				default: len = 31;
			endcase
			return len;
		endfunction

		// Days relative to 1 January 1970, counted with March as the first month.
		function int days_since_epoch(int y, int m, int d);
			int yy, era, yoe, mp, doy, doe;
			yy = (m <= 2) ? y - 1 : y;
			era = yy / 400;
			yoe = yy - era * 400;
			mp = (m > 2) ? m - 3 : m + 9;
			doy = (153 * mp + 2) / 5 + d - 1;
			doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
			return era * 146097 + doe - 719468;
		endfunction

		function void date_from_days(int z, output int y, output int m, output int d);
			int zz, era, doe, yoe, doy, mp;
			zz = z + 719468;
			era = zz / 146097;
			doe = zz - era * 146097;
			yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
			doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
			mp = (5 * doy + 2) / 153;
			d = doy - (153 * mp + 2) / 5 + 1;
			m = (mp < 10) ? mp + 3 : mp - 9;
			y = yoe + era * 400 + ((m <= 2) ? 1 : 0);
		endfunction

		function void accept_command(logic act, logic [4:0] d_in, logic [3:0] m_in,
				logic [11:0] y_in, logic signed [16:0] off);
			int d, m, y, nm, ny, len, z, o, wd;
			logic [1:0] stat;
			date_beat_t beat;
			stat = cdo_pkg::ST_OK;
			if (act == cdo_pkg::ACTION_SET) begin
				set_count++;
				d = d_in;
				m = m_in;
				y = y_in;
				// Month zero and months past December fold into the neighboring year.
				if (m == 0) begin
					nm = 12;
					ny = y - 1;
				end else if (m > 12) begin
					nm = m - 12;
					ny = y + 1;
				end else begin
					nm = m;
					ny = y;
				end
				len = month_days(nm, ny);
				if (d == 0 || d > len) begin
					stat = cdo_pkg::ST_BAD_DAY;
				end else if (nm != m) begin
					stat = cdo_pkg::ST_BAD_MONTH;
				end else if (y < int'(cdo_pkg::YEAR_MIN) || y > int'(cdo_pkg::YEAR_MAX)) begin
					stat = cdo_pkg::ST_BAD_YEAR;
				end else begin
					cur_day = d;
					cur_month = m;
					cur_year = y;
				end
			end else begin
				add_count++;
				o = off;
				z = days_since_epoch(cur_year, cur_month, cur_day) + o;
				date_from_days(z, y, m, d);
				if (y < int'(cdo_pkg::YEAR_MIN) || y > int'(cdo_pkg::YEAR_MAX)) begin
					stat = cdo_pkg::ST_BAD_YEAR;
				end else begin
					cur_day = d;
					cur_month = m;
					cur_year = y;
				end
			end
			z = days_since_epoch(cur_year, cur_month, cur_day);
			wd = ((z % 7) + 11) % 7;
			beat.day = 5'(cur_day);
			beat.month = 4'(cur_month);
			beat.year = 11'(cur_year);
			beat.wday = 3'(wd);
			beat.stat = stat;
			expected_dates.push_back(beat);
		endfunction

		function void check_date_beat(date_beat_t got);
			date_beat_t want;
			if (expected_dates.size() == 0) begin
				$error("result beat with nothing expected: %0d-%0d-%0d status %0d",
					got.year, got.month, got.day, got.stat);
				errors++;
				return;
			end
			want = expected_dates.pop_front();
			status_count[want.stat]++;
			if (got.day !== want.day) begin
				$error("day_out: expected %0d, got %0d", want.day, got.day);
				errors++;
			end
			if (got.month !== want.month) begin
				$error("month_out: expected %0d, got %0d", want.month, got.month);
				errors++;
			end
			if (got.year !== want.year) begin
				$error("year_out: expected %0d, got %0d", want.year, got.year);
				errors++;
			end
			if (got.wday !== want.wday) begin
				$error("weekday: expected %0d, got %0d", want.wday, got.wday);
				errors++;
			end
			if (got.stat !== want.stat) begin
				$error("status: expected %0d, got %0d", want.stat, got.stat);
				errors++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               action = cdo_pkg::ACTION_SET;
	logic [4:0]         day_in = '0;
	logic [3:0]         month_in = '0;
	logic [11:0]        year_in = '0;
	logic signed [16:0] day_offset = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [4:0]         day_out;
	logic [3:0]         month_out;
	logic [10:0]        year_out;
	logic [2:0]         weekday;
	logic [1:0]         status;

	bit calm = 1'b0;
	bit long_hold_req = 1'b0;

	date_tracker tracker = new();

	always #(CLK_PERIOD / 2) clk = ~clk;

	calendar_date_day_offset uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.day_in     (day_in),
		.month_in   (month_in),
		.year_in    (year_in),
		.day_offset (day_offset),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.day_out    (day_out),
		.month_out  (month_out),
		.year_out   (year_out),
		.weekday    (weekday),
		.status     (status)
	);

	task automatic drive_command(input logic act, input logic [4:0] d, input logic [3:0] m,
			input logic [11:0] y, input logic signed [16:0] off);
		in_valid <= 1'b1;
		action <= act;
		day_in <= d;
		month_in <= m;
		year_in <= y;
		day_offset <= off;
		do @(posedge clk); while (!in_ready);
		tracker.accept_command(act, d, m, y, off);
	endtask

	// The offset field is ignored by a set, so it carries noise.
	task automatic send_set(input int d, input int m, input int y);
		drive_command(cdo_pkg::ACTION_SET, 5'(d), 4'(m), 12'(y), 17'($urandom));
	endtask

	task automatic send_add(input int off);
		drive_command(cdo_pkg::ACTION_ADD, 5'($urandom), 4'($urandom), 12'($urandom),
			17'(off));
	endtask

	task automatic idle_input(input int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic maybe_idle();
		if (!calm && $urandom_range(0, 4) == 0) begin
			idle_input($urandom_range(1, 17));
		end
	endtask

	task automatic wait_until_drained();
		in_valid <= 1'b0;
		while (tracker.expected_dates.size() != 0) @(posedge clk);
	endtask

	// Result side: checks each beat and stalls in bursts, or for one long hold on request.
	initial begin
		int stall_left;
		int hold_left;
		date_beat_t got;
		stall_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				got.day = day_out;
				got.month = month_out;
				got.year = year_out;
				got.wday = weekday;
				got.stat = status;
				tracker.check_date_beat(got);
			end
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 17) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		int r, o, yy, mm, dd, waited;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: range ends, leap rules, month folding and add overflow.
		send_set(1, 1, 1902);
		send_set(31, 12, 2037);
		send_set(29, 2, 2000);
		send_set(29, 2, 1900);
		send_set(29, 2, 2100);
		maybe_idle();
		send_set(29, 2, 2004);
		send_set(0, 5, 2000);
		send_set(31, 4, 2001);
		send_set(31, 0, 2000);
		send_set(29, 14, 2003);
		send_set(30, 14, 2003);
		send_set(31, 15, 2010);
		send_set(31, 13, 2037);
		send_set(15, 6, 1901);
		send_set(1, 1, 2038);
		send_set(31, 15, 4095);
		send_set(0, 0, 0);
		send_set(31, 12, 0);
		send_set(10, 10, 2020);
		send_add(0);
		send_add(1);
		send_add(-1);
		send_add(65535);
		send_add(-65536);
		send_set(1, 1, 1902);
		send_add(-1);
		send_add(49672);
		send_add(1);
		send_set(1, 3, 2000);
		send_add(-1);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
			if (i == 250) long_hold_req = 1'b1;
			if (i == 420) wait_until_drained();
			// Keep offering beats during the long hold so the pipeline fills.
			if (i < 250 || i >= 290) maybe_idle();
			r = $urandom_range(0, 99);
			if (r < 30) begin
				yy = $urandom_range(1902, 2037);
				mm = $urandom_range(1, 12);
				dd = $urandom_range(1, tracker.month_days(mm, yy));
				send_set(dd, mm, yy);
			end else if (r < 45) begin
				send_set($urandom_range(0, 31), $urandom_range(0, 15),
					$urandom_range(1900, 2039));
			end else if (r < 55) begin
				send_set($urandom_range(0, 31), $urandom_range(0, 15),
					$urandom_range(0, 4095));
			end else if (r < 70) begin
				o = int'($urandom_range(0, 800)) - 400;
				send_add(o);
			end else if (r < 80) begin
				o = int'($urandom_range(0, 40000)) - 20000;
				send_add(o);
			end else if (r < 93) begin
				send_add(int'($signed(17'($urandom))));
			end else begin
				yy = 4 * $urandom_range(476, 509);
				if ($urandom_range(0, 1) == 0) begin
					send_set(29, 2, yy + $urandom_range(0, 1));
				end else begin
					send_set(29, 14, yy - $urandom_range(0, 1));
				end
			end
		end
		in_valid <= 1'b0;

		waited = 0;
		while (tracker.expected_dates.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (tracker.expected_dates.size() != 0) begin
			$error("%0d expected result beats never arrived", tracker.expected_dates.size());
			tracker.errors++;
		end
		repeat (12) @(posedge clk);

		$display("Covered %0d set and %0d add commands with random stalls on both sides.",
			tracker.set_count, tracker.add_count);
		$display("Statuses seen: %0d ok, %0d bad day, %0d bad month, %0d out of range.",
			tracker.status_count[cdo_pkg::ST_OK], tracker.status_count[cdo_pkg::ST_BAD_DAY],
			tracker.status_count[cdo_pkg::ST_BAD_MONTH],
			tracker.status_count[cdo_pkg::ST_BAD_YEAR]);
		if (tracker.errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#(TIMEOUT_CYCLE * CLK_PERIOD);
		$display("Timed out with %0d result beats outstanding.",
			tracker.expected_dates.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
